[rtl/core/glu_pkg.sv]
// Shared types and constants for the GCD/LCM unit.
// Used by glu_ctrl, glu_datapath and gcd_lcm_unit; depends on nothing else.
package glu_pkg;

  localparam int DATA_WIDTH = 31;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int PROD_W     = 2 * DATA_WIDTH;

  // Operation codes
  localparam logic [1:0] OP_GCD2 = 2'd0;
  localparam logic [1:0] OP_GCD3 = 2'd1;
  localparam logic [1:0] OP_LCM  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_ZERO_LCM = 2'd2;

  // Result source chosen when the result registers are written
  typedef enum logic [1:0] {
    SEL_GCD,
    SEL_LCM,
    SEL_NONE,
    SEL_ZERO_LCM
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_STEP,
    S_LCM_DIV,
    S_MULT,
    S_LCM_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     load_third;
    logic     div_start;
    logic     div_lcm;
    logic     div_step;
    logic     euclid_step;
    logic     mult;
    logic     write;
    res_sel_t sel;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic div_last;
  } dp_stat_t;

endpackage

[rtl/core/glu_datapath.sv]
// Datapath of the GCD/LCM unit: Euclid registers, bit-serial divider,
// multiplier and result registers. Depends on glu_pkg.
module glu_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  glu_pkg::dp_cmd_t             cmd,
  output glu_pkg::dp_stat_t            stat,
  input  logic [glu_pkg::DATA_WIDTH-1:0] first_value,
  input  logic [glu_pkg::DATA_WIDTH-1:0] second_value,
  input  logic [glu_pkg::DATA_WIDTH-1:0] third_value,
  output logic [glu_pkg::DATA_WIDTH-1:0] result_value,
  output logic [1:0]                   status
);
  import glu_pkg::*;

  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  logic [DATA_WIDTH-1:0] a_hold;
  logic [DATA_WIDTH-1:0] b_hold;
  logic [DATA_WIDTH-1:0] c_hold;
  logic [DATA_WIDTH-1:0] div_d;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [CNT_W-1:0]      cnt;
  logic [PROD_W-1:0]     prod;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   trial_diff;
  logic                  prod_ovf;

  // One restoring division step: shift in next dividend bit, try subtract
  always_comb begin
    trial      = {rem, quo[DATA_WIDTH-1]};
    trial_diff = trial - {1'b0, div_d};
  end

  assign prod_ovf = |prod[PROD_W-1:DATA_WIDTH];

  assign stat.x_zero   = (x == '0);
  assign stat.y_zero   = (y == '0);
  assign stat.div_last = (cnt == CNT_W'(DATA_WIDTH - 1));

  // Operand and Euclid registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x      <= first_value;
      y      <= second_value;
      a_hold <= first_value;
      b_hold <= second_value;
      c_hold <= third_value;
    end else if (cmd.load_third) begin
      y <= c_hold;
    end else if (cmd.euclid_step) begin
      x <= y;
      y <= rem;
    end
  end

  // Divider: remainder, quotient and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem   <= '0;
      quo   <= cmd.div_lcm ? a_hold : x;
      div_d <= cmd.div_lcm ? x : y;
    end else if (cmd.div_step) begin
      if (!trial_diff[DATA_WIDTH]) begin
        rem <= trial_diff[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  // Multiply quotient a/g by b
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod <= PROD_W'(quo) * PROD_W'(b_hold);
    end
  end

  // Capture the result of the item
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      case (cmd.sel)
        SEL_GCD: begin
          result_value <= x;
          status       <= STAT_OK;
        end
        SEL_LCM: begin
          result_value <= prod_ovf ? '0 : prod[DATA_WIDTH-1:0];
          status       <= prod_ovf ? STAT_OVERFLOW : STAT_OK;
        end
        SEL_ZERO_LCM: begin
          result_value <= '0;
          status       <= STAT_ZERO_LCM;
        end
        default: begin
          result_value <= '0;
          status       <= STAT_OK;
        end
      endcase
    end
  end

endmodule

[rtl/core/glu_ctrl.sv]
// Controller state machine of the GCD/LCM unit: sequences Euclid steps,
// the LCM division and multiply, and strobes the result. Depends on glu_pkg.
module glu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  glu_pkg::dp_stat_t stat,
  output glu_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import glu_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [1:0] op_reg;
  logic       pass2;
  logic       pass2_next;

  // State, operation and pass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_reg <= OP_GCD2;
      pass2  <= 1'b0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      pass2 <= pass2_next;
      done  <= cmd.write;
      if (state == S_IDLE && start) begin
        op_reg <= op;
      end
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    pass2_next = pass2;
    cmd        = '0;
    cmd.sel    = SEL_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          pass2_next = 1'b0;
          if (op inside {OP_GCD2, OP_GCD3, OP_LCM}) begin
            state_next = S_CHECK;
          end else begin
            cmd.write = 1'b1;
            cmd.sel   = SEL_NONE;
          end
        end
      end
      S_CHECK: begin
        if (!stat.y_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (op_reg == OP_GCD3 && !pass2) begin
          cmd.load_third = 1'b1;
          pass2_next     = 1'b1;
        end else if (op_reg == OP_LCM) begin
          if (stat.x_zero) begin
            cmd.write  = 1'b1;
            cmd.sel    = SEL_ZERO_LCM;
            state_next = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_lcm   = 1'b1;
            state_next    = S_LCM_DIV;
          end
        end else begin
          cmd.write  = 1'b1;
          cmd.sel    = SEL_GCD;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.euclid_step = 1'b1;
        state_next      = S_CHECK;
      end
      S_LCM_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_LCM_OUT;
      end
      S_LCM_OUT: begin
        cmd.write  = 1'b1;
        cmd.sel    = SEL_LCM;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/gcd_lcm_unit.sv]
// GCD/LCM unit: an item is taken when start is high and busy is low; its
// single result appears on result_value and status with done high for one
// cycle, and the receiver cannot stall it. Each Euclid remainder step runs a
// one-bit-per-cycle divider, then one update and one zero check; op 1 adds a
// switch to the third operand after its first pass, and an LCM adds the a/g
// division and multiply. Op 3 is no valid operation; it writes result 0
// with status OK.
// Top level; depends on glu_pkg, glu_ctrl and glu_datapath.
module gcd_lcm_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [glu_pkg::DATA_WIDTH-1:0] first_value,
  input  logic [glu_pkg::DATA_WIDTH-1:0] second_value,
  input  logic [glu_pkg::DATA_WIDTH-1:0] third_value,
  output logic                           done,
  output logic [glu_pkg::DATA_WIDTH-1:0] result_value,
  output logic [1:0]                     status
);
  import glu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  glu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  glu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .first_value  (first_value),
    .second_value (second_value),
    .third_value  (third_value),
    .result_value (result_value),
    .status       (status)
  );

endmodule
